[hdl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hdl/vttrk_pkg.sv]
// ---------------------------------------------------------------------------
// vttrk_pkg
// Shared types and constants of the viewport tile visibility tracker.
// ---------------------------------------------------------------------------
package vttrk_pkg;

  localparam int MaskCols     = 32;
  localparam int MaxDirtyRows = 32;

  typedef enum logic [2:0] {
    CMD_INIT   = 3'd0,
    CMD_SCROLL = 3'd1,
    CMD_MOVE   = 3'd2,
    CMD_RESIZE = 3'd3,
    CMD_CENTER = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    EV_LOST   = 2'd0,
    EV_FOUND  = 2'd1,
    EV_STATUS = 2'd2
  } event_e;

  typedef enum logic [2:0] {
    REG_MAP_W  = 3'd0,
    REG_MAP_H  = 3'd1,
    REG_GRID_W = 3'd2,
    REG_GRID_H = 3'd3,
    REG_INIT_L = 3'd4,
    REG_INIT_T = 3'd5,
    REG_INIT_W = 3'd6,
    REG_INIT_H = 3'd7
  } reg_e;

  // Divider request / response bundle.
  typedef struct packed {
    logic               start;
    logic signed [17:0] num;
    logic        [10:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [17:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic signed [17:0] l;
    logic signed [17:0] t;
    logic signed [17:0] r;
    logic signed [17:0] b;
  } rect_t;

  function automatic logic r_empty(rect_t a);
    r_empty = (a.r <= a.l) || (a.b <= a.t);
  endfunction

  function automatic rect_t r_and(rect_t a, rect_t b);
    rect_t o;
    o.l = (a.l > b.l) ? a.l : b.l;
    o.t = (a.t > b.t) ? a.t : b.t;
    o.r = (a.r < b.r) ? a.r : b.r;
    o.b = (a.b < b.b) ? a.b : b.b;
    r_and = r_empty(o) ? '0 : o;
  endfunction

  function automatic rect_t r_or(rect_t a, rect_t b);
    rect_t o;
    o.l = (a.l < b.l) ? a.l : b.l;
    o.t = (a.t < b.t) ? a.t : b.t;
    o.r = (a.r > b.r) ? a.r : b.r;
    o.b = (a.b > b.b) ? a.b : b.b;
    if (r_empty(a)) r_or = r_empty(b) ? '0 : b;
    else if (r_empty(b)) r_or = a;
    else r_or = o;
  endfunction

  // Column mask of rectangle a on row y, relative to base column.
  function automatic logic [MaskCols-1:0] row_mask(rect_t a, logic signed [17:0] y,
                                                   logic signed [17:0] base);
    logic [MaskCols-1:0] m;
    logic signed [17:0]  x;
    m = '0;
    for (int i = 0; i < MaskCols; i++) begin
      x = base + 18'(i);
      m[i] = (x >= a.l) && (x < a.r) && (y >= a.t) && (y < a.b);
    end
    row_mask = m;
  endfunction

endpackage

[hdl/vttrk_div.sv]
// ---------------------------------------------------------------------------
// vttrk_div
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// ---------------------------------------------------------------------------
module vttrk_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vttrk_pkg::div_req_t req_i,
  output vttrk_pkg::div_rsp_t rsp_o
);
  import vttrk_pkg::*;

  logic [17:0] rem_q, rem_d, quo_q, quo_d;
  logic [10:0] den_q, den_d;
  logic        neg_q, neg_d, busy_q, busy_d, done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [18:0] trial;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    neg_d  = neg_q;
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[17]} - {8'd0, den_q};
    if (req_i.start) begin
      neg_d  = req_i.num[17];
      quo_d  = req_i.num[17] ? 18'(-req_i.num) : req_i.num;
      rem_d  = '0;
      den_d  = (req_i.den == '0) ? 11'd1 : req_i.den;
      cnt_d  = 5'd18;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[18]) begin
        rem_d = trial[17:0];
        quo_d = {quo_q[16:0], 1'b1};
      end else begin
        rem_d = {rem_q[16:0], quo_q[17]};
        quo_d = {quo_q[16:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = neg_q ? 18'(-quo_q) : quo_q;

endmodule

[hdl/viewport_tile_visibility_tracker.sv]
// ---------------------------------------------------------------------------
// viewport_tile_visibility_tracker
// Viewport over a tiled map; reports tile rows lost and found per command.
// ---------------------------------------------------------------------------
// channel | direction | payload
// s_axis  | in        | tdata: cmd, arg_a, arg_b, arg_c, arg_d
// m_axis  | out       | tdata: tile_row, col_base, col_mask; tuser: event_kind,
//         |           | status_ok; tlast: last
// cfg     | in        | cfg_idx_i register index, cfg_data_i value
// A request that moves nothing goes from PREP straight to STAT for its status result.
// Otherwise six divisions run in turn on the shared divider, then the walk visits one
// old dirty row per cycle and then one new dirty row per cycle.
// Output stalls hold the row walk. Reset clears viewport and rectangles to zero.
// A new request is taken once the final result sits in the output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module viewport_tile_visibility_tracker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // cmd[2:0] a[18:3] b[34:19] c[50:35] d[66:51]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // tile_row[12:0] col_base[25:13] col_mask[57:26]
  output logic [2:0]  m_axis_tuser,   // event_kind[1:0] status_ok[2]
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_idx_i,
  input  logic [14:0] cfg_data_i
);
  import vttrk_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_PREP = 7'b0000010,
    ST_DIV  = 7'b0000100,
    ST_EVAL = 7'b0001000,
    ST_LOST = 7'b0010000,
    ST_FND  = 7'b0100000,
    ST_STAT = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [14:0] map_w_q, map_h_q, ini_l_q, ini_t_q, ini_w_q, ini_h_q;
  logic [10:0] grid_w_q, grid_h_q;

  logic signed [17:0] vl_q, vt_q, vw_q, vh_q;
  rect_t cov_q, dty_q;

  // command latches
  logic [2:0]         cmd_q;
  logic signed [17:0] a_q, b_q, c_q, d_q;
  logic signed [17:0] nl_q, nt_q, nw_q, nh_q, dx_q, dy_q;
  logic               ok_q, act_q;
  // divisions: 0 left, 1 top, 2 right-1, 3 bottom-1, 4 map cols, 5 map rows
  logic [2:0]         dstep_q;
  logic               dgo_q;
  logic signed [17:0] q_q [6];
  rect_t              nc_q, nd_q, od_q;
  logic signed [17:0] row_q;

  div_req_t dreq;
  div_rsp_t drsp;

  vttrk_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  assign cfg_ready_o   = (state_q == ST_IDLE);
  assign s_axis_tready = (state_q == ST_IDLE) && !cfg_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_w_q <= 15'd1024; map_h_q <= 15'd1024;
      grid_w_q <= 11'd64;  grid_h_q <= 11'd32;
      ini_l_q <= '0; ini_t_q <= '0; ini_w_q <= 15'd256; ini_h_q <= 15'd128;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (reg_e'(cfg_idx_i))
        REG_MAP_W:  map_w_q  <= cfg_data_i;
        REG_MAP_H:  map_h_q  <= cfg_data_i;
        REG_GRID_W: grid_w_q <= cfg_data_i[10:0];
        REG_GRID_H: grid_h_q <= cfg_data_i[10:0];
        REG_INIT_L: ini_l_q  <= cfg_data_i;
        REG_INIT_T: ini_t_q  <= cfg_data_i;
        REG_INIT_W: ini_w_q  <= cfg_data_i;
        REG_INIT_H: ini_h_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Scroll clamp from current view, and whether the request needs the divider.
  logic signed [17:0] sdx, sdy, cdx, cdy, mw, mh;
  logic               act_now;
  always_comb begin
    mw = 18'(map_w_q);
    mh = 18'(map_h_q);
    case (cmd_e'(cmd_q))
      CMD_MOVE: begin sdx = a_q - vl_q; sdy = b_q - vt_q; end
      CMD_CENTER: begin
        sdx = ((a_q + c_q) / 2) - (vw_q / 2) - vl_q;
        sdy = ((b_q + d_q) / 2) - (vh_q / 2) - vt_q;
      end
      default: begin sdx = a_q; sdy = b_q; end
    endcase
    cdx = sdx;
    if (vl_q + cdx < 0) cdx = -vl_q;
    if (vl_q + vw_q + cdx > mw) cdx = mw - vl_q - vw_q;
    cdy = sdy;
    if (vt_q + cdy < 0) cdy = -vt_q;
    if (vt_q + vh_q + cdy > mh) cdy = mh - vt_q - vh_q;
    case (cmd_e'(cmd_q))
      CMD_INIT:                         act_now = 1'b1;
      CMD_RESIZE:                       act_now = (a_q > 0) && (b_q > 0);
      CMD_SCROLL, CMD_MOVE, CMD_CENTER: act_now = (cdx != 0) || (cdy != 0);
      default:                          act_now = 1'b0;
    endcase
  end

  // Divider operand selection; start each division in the cycle after the last one reports done.
  always_comb begin
    dreq.start = (state_q == ST_DIV) && dgo_q;
    dreq.num   = '0;
    dreq.den   = grid_w_q;
    case (dstep_q)
      3'd0: dreq.num = nl_q;
      3'd1: begin dreq.num = nt_q; dreq.den = grid_h_q; end
      3'd2: dreq.num = nl_q + nw_q - 18'sd1;
      3'd3: begin dreq.num = nt_q + nh_q - 18'sd1; dreq.den = grid_h_q; end
      3'd4: dreq.num = mw + 18'((grid_w_q == '0) ? 11'd1 : grid_w_q) - 18'sd1;
      default: begin
        dreq.num = mh + 18'((grid_h_q == '0) ? 11'd1 : grid_h_q) - 18'sd1;
        dreq.den = grid_h_q;
      end
    endcase
  end

  // Evaluation of the new rectangles.
  rect_t g, cv, ncv, nd, off, infl;
  logic  fits, same;
  logic signed [17:0] sx, sy;
  always_comb begin
    g  = '{l: '0, t: '0, r: q_q[4], b: q_q[5]};
    cv = '{l: q_q[0], t: q_q[1], r: q_q[2] + 18'sd1, b: q_q[3] + 18'sd1};
    ncv = cv;
    if (cmd_q == CMD_INIT) ncv = (a_q != 0) ? r_and(cv, g) : g;
    infl = '{l: ncv.l - 18'sd1, t: ncv.t - 18'sd1, r: ncv.r + 18'sd1, b: ncv.b + 18'sd1};
    sx = (dx_q > 0) ? 18'sd1 : ((dx_q < 0) ? -18'sd1 : 18'sd0);
    sy = (dy_q > 0) ? 18'sd1 : ((dy_q < 0) ? -18'sd1 : 18'sd0);
    off = '{l: ncv.l + sx, t: ncv.t + sy, r: ncv.r + sx, b: ncv.b + sy};
    if (cmd_q == CMD_INIT || cmd_q == CMD_RESIZE) nd = r_and(infl, g);
    else nd = r_and(r_or(ncv, off), g);
    fits = (nd.r - nd.l <= $signed(18'(MaskCols)))
        && (nd.b - nd.t <= $signed(18'(MaxDirtyRows)));
    same = (ncv == cov_q);
  end

  logic [MaskCols-1:0] lmask, fmask;
  always_comb begin
    lmask = row_mask(od_q, row_q, od_q.l) & ~row_mask(nd_q, row_q, od_q.l)
          & ~row_mask(nc_q, row_q, od_q.l);
    fmask = row_mask(nd_q, row_q, nd_q.l) & ~row_mask(od_q, row_q, nd_q.l);
  end

  logic        emit, out_load;
  logic [MaskCols-1:0] emask;
  logic        lost_end, fnd_end, busy_out;
  assign busy_out = m_axis_tvalid && !m_axis_tready;
  always_comb begin
    lost_end = (row_q + 18'sd1 >= od_q.b);
    fnd_end  = (row_q + 18'sd1 >= nd_q.b);
    emit = 1'b0; emask = '0;
    if (state_q == ST_LOST) begin
      emask = lmask; emit = (row_q < od_q.b) && (lmask != '0);
    end else if (state_q == ST_FND) begin
      emask = fmask; emit = (row_q < nd_q.b) && (fmask != '0);
    end
  end

  // Output register; a row is emitted one behind so tlast can be set.
  logic               pend_q;
  logic [1:0]         pk_q;
  logic [12:0]        pr_q, pb_q;
  logic [MaskCols-1:0] pm_q;

  // Load the output register with the held row, or with the final result.
  assign out_load = !busy_out && ((state_q == ST_STAT) ||
                    ((state_q == ST_LOST || state_q == ST_FND) && emit && pend_q));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (s_axis_tvalid && s_axis_tready) state_d = ST_PREP;
      ST_PREP: state_d = act_now ? ST_DIV : ST_STAT;
      ST_DIV:  if (drsp.done && dstep_q == 3'd5) state_d = ST_EVAL;
      ST_EVAL: state_d = ST_LOST;
      ST_LOST: if (!busy_out && (row_q >= od_q.b || lost_end)) state_d = ST_FND;
      ST_FND:  if (!busy_out && (row_q >= nd_q.b || fnd_end)) state_d = ST_STAT;
      ST_STAT: if (!busy_out) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      vl_q <= '0; vt_q <= '0; vw_q <= '0; vh_q <= '0;
      cov_q <= '0; dty_q <= '0;
      m_axis_tvalid <= 1'b0;
      pend_q <= 1'b0;
      dstep_q <= '0;
      dgo_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state_q)
        ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          cmd_q <= s_axis_tdata[2:0];
          a_q <= 18'(signed'(s_axis_tdata[18:3]));
          b_q <= 18'(signed'(s_axis_tdata[34:19]));
          c_q <= 18'(signed'(s_axis_tdata[50:35]));
          d_q <= 18'(signed'(s_axis_tdata[66:51]));
          pend_q <= 1'b0;
        end
        ST_PREP: begin
          dstep_q <= '0;
          dgo_q <= 1'b1;
          act_q <= act_now;
          case (cmd_e'(cmd_q))
            CMD_INIT: begin
              nl_q <= 18'(ini_l_q); nt_q <= 18'(ini_t_q);
              nw_q <= 18'(ini_w_q); nh_q <= 18'(ini_h_q);
              od_q <= '0; ok_q <= 1'b0;
            end
            CMD_RESIZE: begin
              nl_q <= vl_q; nt_q <= vt_q; nw_q <= a_q; nh_q <= b_q;
              dx_q <= '0; dy_q <= '0;
              od_q <= dty_q; ok_q <= 1'b0;
            end
            CMD_SCROLL, CMD_MOVE, CMD_CENTER: begin
              nl_q <= vl_q + cdx; nt_q <= vt_q + cdy; nw_q <= vw_q; nh_q <= vh_q;
              dx_q <= cdx; dy_q <= cdy;
              od_q <= dty_q;
              ok_q <= (cmd_q == CMD_MOVE);
            end
            default: begin
              od_q <= dty_q; ok_q <= 1'b0;
            end
          endcase
        end
        ST_DIV: begin
          if (drsp.done) begin
            q_q[dstep_q] <= drsp.quo;
            dstep_q <= dstep_q + 3'd1;
          end
          dgo_q <= drsp.done && (dstep_q != 3'd5);
        end
        ST_EVAL: begin
          if (cmd_q != CMD_INIT && same) begin
            // Same cover: update the viewport, emit no rows.
            ok_q <= 1'b1;
            nd_q <= dty_q; nc_q <= cov_q; od_q <= dty_q;
            vl_q <= nl_q; vt_q <= nt_q; vw_q <= nw_q; vh_q <= nh_q;
            row_q <= dty_q.b;
          end else if (fits) begin
            ok_q <= 1'b1;
            nc_q <= ncv; nd_q <= nd;
            vl_q <= nl_q; vt_q <= nt_q; vw_q <= nw_q; vh_q <= nh_q;
            cov_q <= ncv; dty_q <= nd;
            row_q <= od_q.t;
          end else begin
            // Oversize dirty area: drop the request, keep all state.
            nc_q <= ncv; nd_q <= '0; od_q <= '0;
            row_q <= '0;
          end
        end
        ST_LOST, ST_FND: if (!busy_out) begin
          if (emit) begin
            if (pend_q) begin
              m_axis_tdata <= {6'd0, pm_q, pb_q, pr_q};
              m_axis_tuser <= {ok_q, pk_q};
              m_axis_tlast <= 1'b0;
            end
            pend_q <= 1'b1;
            pk_q <= (state_q == ST_LOST) ? EV_LOST : EV_FOUND;
            pr_q <= row_q[12:0];
            pb_q <= (state_q == ST_LOST) ? od_q.l[12:0] : nd_q.l[12:0];
            pm_q <= emask;
          end
          if (state_d == ST_FND && state_q == ST_LOST) row_q <= nd_q.t;
          else row_q <= row_q + 18'sd1;
        end
        ST_STAT: if (!busy_out) begin
          m_axis_tlast  <= 1'b1;
          if (pend_q && act_q) begin
            m_axis_tdata <= {6'd0, pm_q, pb_q, pr_q};
            m_axis_tuser <= {ok_q, pk_q};
          end else begin
            m_axis_tdata <= '0;
            m_axis_tuser <= {ok_q, EV_STATUS};
          end
        end
        default: ;
      endcase
    end
  end

  `ASSERT_IMPL(a_no_accept_busy, clk_i, rst_ni, state_q != ST_IDLE, !s_axis_tready)
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
               m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
  `ASSERT_NEXT(a_div_step, clk_i, rst_ni, state_q == ST_EVAL, dstep_q == 3'd6)

endmodule
